>>> rtl/sccc_pkg.sv
// ============================================================================
// sccc_pkg : segment/curve crossing check shared definitions
// Widths, types, register map and arithmetic helpers used by the interfaces
// and the crossing check datapath.
// ============================================================================
package sccc_pkg;

  // Coordinate and vertex id widths
  localparam int COORD_BITS = 16;
  localparam int IDENT_BITS = 16;
  localparam int TOL_BITS   = 32;

  // Derived arithmetic widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CMP_W  = ((SUM_W > TOL_BITS) ? SUM_W : TOL_BITS) + 1;

  // Configuration port
  localparam int DATA_W    = 32;
  localparam int NUM_REGS  = 7;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int ADDR_W    = REG_IDX_W + 2;

  localparam logic [REG_IDX_W-1:0] REG_SEG_AX    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_SEG_AY    = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_SEG_BX    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_SEG_BY    = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_SEG_A_ID  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_SEG_B_ID  = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = REG_IDX_W'(6);

  // Reset id of the query segment's second endpoint
  localparam logic [IDENT_BITS-1:0] SEG_B_ID_RST = IDENT_BITS'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [IDENT_BITS-1:0] ident_t;
  typedef logic        [TOL_BITS-1:0]   tol_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [CMP_W-1:0]      cmp_t;

  // Orientation codes
  typedef logic [1:0] spin_t;
  localparam spin_t SPIN_COL = 2'd0;
  localparam spin_t SPIN_CW  = 2'd1;
  localparam spin_t SPIN_CCW = 2'd2;

  // Exact difference of two coordinates
  function automatic diff_t diff(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = diff_t'(a);
    eb = diff_t'(b);
    return ea - eb;
  endfunction

  // Exact product of two differences
  function automatic prod_t mul(diff_t a, diff_t b);
    prod_t ea;
    prod_t eb;
    ea = prod_t'(a);
    eb = prod_t'(b);
    return ea * eb;
  endfunction

  // Classify an orientation value against the collinear tolerance
  function automatic spin_t spin_of(prod_t lhs, prod_t rhs, tol_t tol);
    sum_t  o;
    cmp_t  oe;
    cmp_t  te;
    spin_t s;
    o  = sum_t'(lhs) - sum_t'(rhs);
    oe = cmp_t'(o);
    te = $signed(CMP_W'(tol));
    if (oe > te) begin
      s = SPIN_CW;
    end else if (oe < -te) begin
      s = SPIN_CCW;
    end else begin
      s = SPIN_COL;
    end
    return s;
  endfunction

endpackage

>>> rtl/sccc_in_if.sv
// ============================================================================
// sccc_in_if : curve vertex channel
// Valid/ready channel carrying one polyline vertex per transaction.
// ============================================================================
interface sccc_in_if;
  logic               valid;
  logic               ready;
  sccc_pkg::coord_t   curve_x;
  sccc_pkg::coord_t   curve_y;
  sccc_pkg::ident_t   curve_ident;
  logic               last_vertex;

  modport source (output valid, curve_x, curve_y, curve_ident, last_vertex,
                  input ready);
  modport sink   (input valid, curve_x, curve_y, curve_ident, last_vertex,
                  output ready);
endinterface

>>> rtl/sccc_out_if.sv
// ============================================================================
// sccc_out_if : crossing result channel
// Valid/ready channel carrying one crossing flag per finished curve.
// ============================================================================
interface sccc_out_if;
  logic valid;
  logic ready;
  logic crosses;

  modport source (output valid, crosses, input ready);
  modport sink   (input valid, crosses, output ready);
endinterface

>>> rtl/segment_curve_crossing_check.sv
// ============================================================================
// segment_curve_crossing_check : query segment versus polyline crossing test
// Streams polyline vertices, tests each closed edge against the configured
// query segment and reports one crossing flag per curve.
// ============================================================================
// Usage:
//   Program the query segment (endpoints, endpoint ids, collinear tolerance)
//   over the APB port while the block is idle. Then stream the curve's
//   vertices on in_ch, one transaction each, with last_vertex set on the
//   final one. Each vertex after the first closes an edge with the previous
//   vertex. On the last vertex one transaction on out_ch reports whether any
//   edge crossed the segment; other vertices give no result. A one-vertex
//   curve reports no crossing.
// Timing:
//   Three register stages: input register, product register (eighteen
//   parallel 17x17 multiplies) and result register. A vertex accepted on
//   in_ch moves through the input and product registers to out_ch. Unless
//   out_ch stalls, one vertex is accepted every cycle (single product stage).
// Reset:
//   rst_n (synchronous, active low) empties the pipeline, starts a new curve
//   and loads the register reset values (second endpoint id 1, others 0).
// Back-pressure:
//   While a result waits on out_ch with ready low, the whole pipeline holds
//   and in_ch.ready drops; no vertex or result is lost.
// ============================================================================
module segment_curve_crossing_check (
  input  logic                            clk,
  input  logic                            rst_n,
  sccc_in_if.sink                         in_ch,
  sccc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sccc_pkg::ADDR_W-1:0]     paddr,
  input  logic [sccc_pkg::DATA_W-1:0]     pwdata,
  output logic [sccc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  sccc_pkg::coord_t seg_ax_r, seg_ay_r, seg_bx_r, seg_by_r;
  sccc_pkg::ident_t seg_a_id_r, seg_b_id_r;
  sccc_pkg::tol_t   tol_r;

  logic                             cfg_wr;
  logic [sccc_pkg::REG_IDX_W-1:0]   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[sccc_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write the addressed register; unknown addresses are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_ax_r   <= '0;
      seg_ay_r   <= '0;
      seg_bx_r   <= '0;
      seg_by_r   <= '0;
      seg_a_id_r <= '0;
      seg_b_id_r <= sccc_pkg::SEG_B_ID_RST;
      tol_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sccc_pkg::REG_SEG_AX:    seg_ax_r   <= pwdata[sccc_pkg::COORD_BITS-1:0];
        sccc_pkg::REG_SEG_AY:    seg_ay_r   <= pwdata[sccc_pkg::COORD_BITS-1:0];
        sccc_pkg::REG_SEG_BX:    seg_bx_r   <= pwdata[sccc_pkg::COORD_BITS-1:0];
        sccc_pkg::REG_SEG_BY:    seg_by_r   <= pwdata[sccc_pkg::COORD_BITS-1:0];
        sccc_pkg::REG_SEG_A_ID:  seg_a_id_r <= pwdata[sccc_pkg::IDENT_BITS-1:0];
        sccc_pkg::REG_SEG_B_ID:  seg_b_id_r <= pwdata[sccc_pkg::IDENT_BITS-1:0];
        sccc_pkg::REG_TOLERANCE: tol_r      <= pwdata[sccc_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      sccc_pkg::REG_SEG_AX:    prdata = sccc_pkg::DATA_W'($unsigned(seg_ax_r));
      sccc_pkg::REG_SEG_AY:    prdata = sccc_pkg::DATA_W'($unsigned(seg_ay_r));
      sccc_pkg::REG_SEG_BX:    prdata = sccc_pkg::DATA_W'($unsigned(seg_bx_r));
      sccc_pkg::REG_SEG_BY:    prdata = sccc_pkg::DATA_W'($unsigned(seg_by_r));
      sccc_pkg::REG_SEG_A_ID:  prdata = sccc_pkg::DATA_W'(seg_a_id_r);
      sccc_pkg::REG_SEG_B_ID:  prdata = sccc_pkg::DATA_W'(seg_b_id_r);
      sccc_pkg::REG_TOLERANCE: prdata = sccc_pkg::DATA_W'(tol_r);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: move everything when the result slot is free or taken
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic out_crosses_r;
  logic adv;
  logic in_acc;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc      = in_ch.valid && adv;

  // --------------------------------------------------------------------------
  // Previous vertex tracking
  // --------------------------------------------------------------------------
  sccc_pkg::coord_t prev_x_r, prev_y_r;
  sccc_pkg::ident_t prev_id_r;
  logic             have_prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_id_r   <= '0;
      have_prev_r <= 1'b0;
    end else if (in_acc) begin
      prev_x_r    <= in_ch.curve_x;
      prev_y_r    <= in_ch.curve_y;
      prev_id_r   <= in_ch.curve_ident;
      have_prev_r <= !in_ch.last_vertex;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register holding the edge P-C
  // --------------------------------------------------------------------------
  logic             s1_valid_r, s1_last_r, s1_edge_r;
  sccc_pkg::coord_t s1_cx_r, s1_cy_r, s1_px_r, s1_py_r;
  sccc_pkg::ident_t s1_cid_r, s1_pid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r <= in_ch.last_vertex;
      s1_edge_r <= have_prev_r;
      s1_cx_r   <= in_ch.curve_x;
      s1_cy_r   <= in_ch.curve_y;
      s1_cid_r  <= in_ch.curve_ident;
      s1_px_r   <= prev_x_r;
      s1_py_r   <= prev_y_r;
      s1_pid_r  <= prev_id_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 logic: differences, y-range prefilter, id matches
  // --------------------------------------------------------------------------
  sccc_pkg::diff_t  d_ux, d_uy;            // C - P
  sccc_pkg::diff_t  d_vax, d_vay;          // A - P
  sccc_pkg::diff_t  d_vbx, d_vby;          // B - P
  sccc_pkg::diff_t  d_acx, d_acy;          // A - C
  sccc_pkg::diff_t  d_bcx, d_bcy;          // B - C
  sccc_pkg::diff_t  d_abx, d_aby;          // B - A
  sccc_pkg::diff_t  d_pbx, d_pby;          // P - B
  sccc_pkg::diff_t  d_cbx, d_cby;          // C - B
  sccc_pkg::coord_t smin, smax, cmin, cmax;
  logic             pass_y;

  always_comb begin
    d_ux  = sccc_pkg::diff(s1_cx_r, s1_px_r);
    d_uy  = sccc_pkg::diff(s1_cy_r, s1_py_r);
    d_vax = sccc_pkg::diff(seg_ax_r, s1_px_r);
    d_vay = sccc_pkg::diff(seg_ay_r, s1_py_r);
    d_vbx = sccc_pkg::diff(seg_bx_r, s1_px_r);
    d_vby = sccc_pkg::diff(seg_by_r, s1_py_r);
    d_acx = sccc_pkg::diff(seg_ax_r, s1_cx_r);
    d_acy = sccc_pkg::diff(seg_ay_r, s1_cy_r);
    d_bcx = sccc_pkg::diff(seg_bx_r, s1_cx_r);
    d_bcy = sccc_pkg::diff(seg_by_r, s1_cy_r);
    d_abx = sccc_pkg::diff(seg_bx_r, seg_ax_r);
    d_aby = sccc_pkg::diff(seg_by_r, seg_ay_r);
    d_pbx = sccc_pkg::diff(s1_px_r, seg_bx_r);
    d_pby = sccc_pkg::diff(s1_py_r, seg_by_r);
    d_cbx = sccc_pkg::diff(s1_cx_r, seg_bx_r);
    d_cby = sccc_pkg::diff(s1_cy_r, seg_by_r);

    // y-range overlap of segment and edge
    smin   = (seg_ay_r < seg_by_r) ? seg_ay_r : seg_by_r;
    smax   = (seg_ay_r < seg_by_r) ? seg_by_r : seg_ay_r;
    cmin   = (s1_py_r < s1_cy_r) ? s1_py_r : s1_cy_r;
    cmax   = (s1_py_r < s1_cy_r) ? s1_cy_r : s1_py_r;
    pass_y = (s1_py_r >= smin && s1_py_r <= smax) ||
             (s1_cy_r >= smin && s1_cy_r <= smax) ||
             (seg_ay_r >= cmin && seg_ay_r <= cmax) ||
             (seg_by_r >= cmin && seg_by_r <= cmax);
  end

  // --------------------------------------------------------------------------
  // Stage 2: product register
  // --------------------------------------------------------------------------
  logic             s2_valid_r, s2_last_r, s2_edge_r;
  logic             s2_shared_r, s2_a_ok_r, s2_b_ok_r, s2_a_eq_c_r, s2_b_eq_c_r;
  sccc_pkg::prod_t  ori_l_r [4];
  sccc_pkg::prod_t  ori_r_r [4];
  sccc_pkg::prod_t  dot_x_r [2];
  sccc_pkg::prod_t  dot_y_r [2];
  sccc_pkg::prod_t  lenv_x_r [2];
  sccc_pkg::prod_t  lenv_y_r [2];
  sccc_pkg::prod_t  lenu_x_r, lenu_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r   <= s1_last_r;
      s2_edge_r   <= s1_edge_r && pass_y;
      s2_shared_r <= (seg_a_id_r == s1_pid_r) || (seg_a_id_r == s1_cid_r) ||
                     (seg_b_id_r == s1_pid_r) || (seg_b_id_r == s1_cid_r);
      s2_a_ok_r   <= (s1_pid_r != seg_a_id_r) && (s1_cid_r != seg_a_id_r);
      s2_b_ok_r   <= (s1_pid_r != seg_b_id_r) && (s1_cid_r != seg_b_id_r);
      s2_a_eq_c_r <= (seg_a_id_r == s1_cid_r);
      s2_b_eq_c_r <= (seg_b_id_r == s1_cid_r);

      // Orientations (P,C,A), (P,C,B), (A,B,P), (A,B,C)
      ori_l_r[0] <= sccc_pkg::mul(d_uy, d_acx);
      ori_r_r[0] <= sccc_pkg::mul(d_acy, d_ux);
      ori_l_r[1] <= sccc_pkg::mul(d_uy, d_bcx);
      ori_r_r[1] <= sccc_pkg::mul(d_bcy, d_ux);
      ori_l_r[2] <= sccc_pkg::mul(d_aby, d_pbx);
      ori_r_r[2] <= sccc_pkg::mul(d_pby, d_abx);
      ori_l_r[3] <= sccc_pkg::mul(d_aby, d_cbx);
      ori_r_r[3] <= sccc_pkg::mul(d_cby, d_abx);

      // Far vertex terms for query endpoints A and B
      dot_x_r[0]  <= sccc_pkg::mul(d_ux, d_vax);
      dot_y_r[0]  <= sccc_pkg::mul(d_uy, d_vay);
      dot_x_r[1]  <= sccc_pkg::mul(d_ux, d_vbx);
      dot_y_r[1]  <= sccc_pkg::mul(d_uy, d_vby);
      lenv_x_r[0] <= sccc_pkg::mul(d_vax, d_vax);
      lenv_y_r[0] <= sccc_pkg::mul(d_vay, d_vay);
      lenv_x_r[1] <= sccc_pkg::mul(d_vbx, d_vbx);
      lenv_y_r[1] <= sccc_pkg::mul(d_vby, d_vby);
      lenu_x_r    <= sccc_pkg::mul(d_ux, d_ux);
      lenu_y_r    <= sccc_pkg::mul(d_uy, d_uy);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 logic: classify orientations and decide the edge
  // --------------------------------------------------------------------------
  sccc_pkg::spin_t sp [4];
  sccc_pkg::sum_t  dot_s [2];
  sccc_pkg::sum_t  lenv_s [2];
  sccc_pkg::sum_t  lenu_s;
  logic            dot_ok [2];
  logic            v_longer [2];
  logic            all_col, incl_hit, excl_hit, edge_hit, found_nxt;
  logic            found_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sp[k] = sccc_pkg::spin_of(ori_l_r[k], ori_r_r[k], tol_r);
    end
    lenu_s = sccc_pkg::sum_t'(lenu_x_r) + sccc_pkg::sum_t'(lenu_y_r);
    for (int k = 0; k < 2; k++) begin
      dot_s[k]    = sccc_pkg::sum_t'(dot_x_r[k]) + sccc_pkg::sum_t'(dot_y_r[k]);
      lenv_s[k]   = sccc_pkg::sum_t'(lenv_x_r[k]) + sccc_pkg::sum_t'(lenv_y_r[k]);
      dot_ok[k]   = !dot_s[k][sccc_pkg::SUM_W-1];
      v_longer[k] = lenv_s[k] > lenu_s;
    end

    all_col = (sp[0] == sccc_pkg::SPIN_COL) && (sp[1] == sccc_pkg::SPIN_COL) &&
              (sp[2] == sccc_pkg::SPIN_COL) && (sp[3] == sccc_pkg::SPIN_COL);

    // Inclusive test: proper crossing, or collinear overlap reaching C
    incl_hit = ((sp[0] != sp[1]) && (sp[2] != sp[3])) ||
               (all_col && ((dot_ok[0] && (!v_longer[0] || s2_a_eq_c_r)) ||
                            (dot_ok[1] && (!v_longer[1] || s2_b_eq_c_r))));

    // Non-inclusive test: collinear overlap by an endpoint that is not a vertex of the edge
    excl_hit = all_col && ((s2_a_ok_r && dot_ok[0] && !v_longer[0]) ||
                           (s2_b_ok_r && dot_ok[1] && !v_longer[1]));

    edge_hit  = s2_valid_r && s2_edge_r && (s2_shared_r ? excl_hit : incl_hit);
    found_nxt = found_r || edge_hit;
  end

  // --------------------------------------------------------------------------
  // Crossing accumulation and result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r && s2_last_r;
      if (s2_valid_r) begin
        found_r <= s2_last_r ? 1'b0 : found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r && s2_last_r) begin
      out_crosses_r <= found_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.crosses = out_crosses_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A result appears only after the last vertex of a curve left stage 2
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_valid_r && s2_last_r && adv))
    else $error("result without a last vertex");

  // The crossing flag clears once a curve has been reported
  a_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_valid_r && s2_last_r) |=> !found_r)
    else $error("crossing flag carried into the next curve");

  // A last vertex starts a new curve
  a_new_curve: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_vertex) |=> !have_prev_r)
    else $error("previous vertex kept across curves");

  // A vertex without a previous one, or an edge outside the segment's y-range, never flags a crossing
  a_no_edge_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_edge_r) |-> !edge_hit)
    else $error("crossing on an edge that was not formed");

endmodule
